>>> hdl/smt_pkg.sv
package smt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming opcode and value
    logic exec;  // apply the operation and load the result register
  } cmd_t;

endpackage

>>> hdl/smt_ctrl.sv
module smt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output smt_pkg::cmd_t cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  assign in_stall = (state == EXEC);
  assign cmd.load = in_valid && (state == IDLE);
  // The operation is applied only when the result register can take its result.
  assign cmd.exec = (state == EXEC) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (cmd.exec) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/smt_datapath.sv
module smt_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smt_pkg::cmd_t                        cmd,
  input  logic [1:0]                           opcode,
  input  logic signed [smt_pkg::VALUE_W-1:0]   value,
  output logic [1:0]                           status,
  output logic                                 found,
  output logic [smt_pkg::COUNT_W-1:0]          entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]                          op_q;
  logic signed [smt_pkg::VALUE_W-1:0]  val_q;
  logic signed [smt_pkg::VALUE_W-1:0]  entries [CAPACITY];
  logic [CW-1:0]                       count;

  logic signed [smt_pkg::VALUE_W-1:0]  ins_val [CAPACITY];
  logic signed [smt_pkg::VALUE_W-1:0]  del_val [CAPACITY];
  logic [CAPACITY-1:0]                 live;
  logic [CAPACITY-1:0]                 above;
  logic [CAPACITY-1:0]                 at_or_above;
  logic [CAPACITY-1:0]                 equal;
  logic                                any_equal;
  logic                                is_full;
  logic                                is_empty;
  logic                                wr_ins;
  logic                                wr_del;
  logic [1:0]                          status_next;
  logic                                found_next;
  logic [CW-1:0]                       count_next;
  logic [CW+smt_pkg::COUNT_W-1:0]      count_ext;

  // Every cell compares against the broadcast value at the same time.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign live[i]        = CW'(i) < count;
    assign above[i]       = !live[i] || (entries[i] > val_q);
    assign at_or_above[i] = live[i] && (entries[i] >= val_q);
    assign equal[i]       = live[i] && (entries[i] == val_q);

    // Insert: cells past the insertion point take their left neighbor.
    if (i == 0) begin : g_first
      assign ins_val[i] = above[i] ? val_q : entries[i];
    end else begin : g_rest
      assign ins_val[i] = (live[i-1] && above[i-1]) ? entries[i-1] :
                          above[i] ? val_q : entries[i];
    end

    // Delete: cells from the first match on take their right neighbor.
    if (i == CAPACITY - 1) begin : g_last
      assign del_val[i] = entries[i];
    end else begin : g_inner
      assign del_val[i] = at_or_above[i] ? entries[i+1] : entries[i];
    end
  end

  assign any_equal = |equal;
  assign is_full   = (count == CW'(CAPACITY));
  assign is_empty  = (count == '0);

  always_comb begin
    status_next = smt_pkg::ST_OK;
    found_next  = 1'b0;
    count_next  = count;
    wr_ins      = 1'b0;
    wr_del      = 1'b0;
    case (op_q)
      smt_pkg::OP_INSERT: begin
        if (is_full) begin
          status_next = smt_pkg::ST_FULL;
        end else begin
          wr_ins     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      smt_pkg::OP_SEARCH: begin
        if (is_empty) begin
          status_next = smt_pkg::ST_EMPTY;
        end else begin
          found_next = any_equal;
        end
      end
      smt_pkg::OP_DELETE: begin
        if (is_empty) begin
          status_next = smt_pkg::ST_EMPTY;
        end else if (any_equal) begin
          wr_del     = 1'b1;
          found_next = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign count_ext = {{smt_pkg::COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      val_q <= value;
    end
    if (cmd.exec) begin
      status      <= status_next;
      found       <= found_next;
      entry_count <= count_ext[smt_pkg::COUNT_W-1:0];
      for (int i = 0; i < CAPACITY; i++) begin
        if (wr_ins) begin
          entries[i] <= ins_val[i];
        end else if (wr_del) begin
          entries[i] <= del_val[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

endmodule

>>> hdl/sorted_multiset_table_unit.sv
// Sorted multiset table: holds up to CAPACITY signed 32-bit values in
// ascending order, duplicates allowed.
// Input channel (in_valid, in_stall, opcode, value): one transaction per
// operation, where opcode selects insert, search or delete of one occurrence.
// Output channel (out_valid, out_stall, status, found, entry_count): exactly
// one transaction per input, in order, carrying the count after the operation.
// Each operation is first captured into the input registers; then, in the
// execute state, the whole row of cells compares against the value and
// shifts in parallel, and the result is loaded into the output register.
// A new operation is accepted only once the previous one has executed.
// A new transaction is taken while the previous result still waits in the
// output register. When the receiver stalls with a result pending, the next
// operation waits in its execute state and the input side stalls.
// Reset empties the table at once; no clearing pass is needed, since only
// positions below the count are ever read.
module sorted_multiset_table_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         opcode,
  input  logic signed [smt_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic                               found,
  output logic [smt_pkg::COUNT_W-1:0]        entry_count
);

  smt_pkg::cmd_t cmd;

  smt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  smt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .value       (value),
    .status      (status),
    .found       (found),
    .entry_count (entry_count)
  );

endmodule

>>> hdl/smt_checker.sv
module smt_checker #(
  parameter int CAPACITY = 32
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         opcode,
  input logic signed [smt_pkg::VALUE_W-1:0] value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [1:0]                         status,
  input logic                               found,
  input logic [smt_pkg::COUNT_W-1:0]        entry_count
);

  // The block is busy for the cycle after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(found)
                                  && $stable(entry_count)))
    else $error("stalled result changed");

  // An empty-store error reports an empty store and no match.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == smt_pkg::ST_EMPTY) |-> (entry_count == '0 && !found))
    else $error("empty error with nonzero count or match");

  // A full insert reports no match and a full count.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == smt_pkg::ST_FULL) |->
      (!found && entry_count == smt_pkg::COUNT_W'(CAPACITY)))
    else $error("full status with wrong count or match");

endmodule

bind sorted_multiset_table_unit smt_checker #(.CAPACITY(CAPACITY)) u_smt_checker (.*);
